// ===== src/npic_pkg.sv =====
// Shared types and codes for the nested priority interrupt controller.
// Command and response words, line flags, sequencer states. No dependencies.
`timescale 1ns / 1ps

package npic_pkg;

  localparam int IrqW      = 6;
  localparam int PriInW    = 4;
  localparam int DepthOutW = 5;
  localparam int TotalW    = 32;

  typedef enum logic [2:0] {
    MODE_SET_PRI     = 3'd0,
    MODE_ENABLE      = 3'd1,
    MODE_DISABLE     = 3'd2,
    MODE_SET_PENDING = 3'd3,
    MODE_DISPATCH    = 3'd4,
    MODE_RETURN      = 3'd5,
    MODE_CLEAR_COUNT = 3'd6
  } npic_mode_t;

  typedef enum logic [1:0] {
    STATUS_NONE        = 2'd0,
    STATUS_ENTERED     = 2'd1,
    STATUS_RET_IGNORED = 2'd2
  } npic_status_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [IrqW-1:0]   irq_index;
    logic [PriInW-1:0] priority_value;
  } npic_cmd_t;

  typedef struct packed {
    npic_status_t         status;
    logic [IrqW-1:0]      entered_irq;
    logic                 preempted;
    logic                 active_valid;
    logic [IrqW-1:0]      active_irq;
    logic [DepthOutW-1:0] nest_depth;
    logic [TotalW-1:0]    preemption_total;
  } npic_rsp_t;

  typedef struct packed {
    logic enable;
    logic pending;
    logic active;
  } npic_flags_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LINE_WR,
    ST_RET_WR,
    ST_POP_WAIT,
    ST_POP_PRI,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_COMMIT,
    ST_DONE
  } npic_state_t;

endpackage

// ===== src/npic_line_table.sv =====
// Per-line table: priority, enable, pending and active flags in one synchronous RAM.
// Per-entry written bits make unwritten entries read as the reset value. Uses npic_pkg.
`timescale 1ns / 1ps

module npic_line_table #(
  parameter int NUM_LINES     = 64,
  parameter int PRIORITY_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_LINES)-1:0] rd_addr,
  output logic [PRIORITY_BITS-1:0]     rd_pri,
  output npic_pkg::npic_flags_t        rd_flags,
  input  logic                         wr_en,
  input  logic [$clog2(NUM_LINES)-1:0] wr_addr,
  input  logic [PRIORITY_BITS-1:0]     wr_pri,
  input  npic_pkg::npic_flags_t        wr_flags
);

  localparam int EntryW = PRIORITY_BITS + 3;

  logic [EntryW-1:0]    mem [NUM_LINES];
  logic [NUM_LINES-1:0] written;
  logic [EntryW-1:0]    rd_q;
  logic                 rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_pri, wr_flags};
    end
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // never-written entries: lowest urgency, all flags clear
  assign rd_pri   = rd_written ? rd_q[EntryW-1:3] : '1;
  assign rd_flags = rd_written ? npic_pkg::npic_flags_t'(rd_q[2:0]) : '0;

endmodule

// ===== src/npic_ret_stack.sv =====
// Return stack of interrupted handlers: synchronous RAM plus depth counter.
// Pop data is registered and valid the cycle after pop. No package use.
`timescale 1ns / 1ps

module npic_ret_stack #(
  parameter int NEST_DEPTH = 16,
  parameter int LINE_W     = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [LINE_W-1:0]               push_line,
  input  logic                            pop,
  output logic [LINE_W-1:0]               pop_line,
  output logic [$clog2(NEST_DEPTH+1)-1:0] depth,
  output logic                            full,
  output logic                            empty
);

  localparam int SlotW  = $clog2(NEST_DEPTH);
  localparam int DepthW = $clog2(NEST_DEPTH + 1);

  logic [LINE_W-1:0] mem [NEST_DEPTH];
  logic [DepthW-1:0] top_slot;

  assign top_slot = depth - DepthW'(1);
  assign full     = (depth == DepthW'(NEST_DEPTH));
  assign empty    = (depth == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[depth[SlotW-1:0]] <= push_line;
    end
    if (pop) begin
      pop_line <= mem[top_slot[SlotW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (push) begin
      depth <= depth + DepthW'(1);
    end else if (pop) begin
      depth <= depth - DepthW'(1);
    end
  end

endmodule

// ===== src/npic_ctrl.sv =====
// Sequencer: decodes a command word, runs read-modify-write on the line table,
// scans it for dispatch and drives the return stack. Uses npic_pkg.
`timescale 1ns / 1ps

module npic_ctrl #(
  parameter int NUM_LINES     = 64,
  parameter int PRIORITY_BITS = 4,
  parameter int NEST_DEPTH    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  npic_pkg::npic_cmd_t             cmd,
  output logic                            busy,
  input  logic                            res_ready,
  output logic                            res_valid,
  output npic_pkg::npic_rsp_t             res,
  output logic                            tb_rd_en,
  output logic [$clog2(NUM_LINES)-1:0]    tb_rd_addr,
  input  logic [PRIORITY_BITS-1:0]        tb_rd_pri,
  input  npic_pkg::npic_flags_t           tb_rd_flags,
  output logic                            tb_wr_en,
  output logic [$clog2(NUM_LINES)-1:0]    tb_wr_addr,
  output logic [PRIORITY_BITS-1:0]        tb_wr_pri,
  output npic_pkg::npic_flags_t           tb_wr_flags,
  output logic                            st_push,
  output logic [$clog2(NUM_LINES)-1:0]    st_push_line,
  output logic                            st_pop,
  input  logic [$clog2(NUM_LINES)-1:0]    st_pop_line,
  input  logic [$clog2(NEST_DEPTH+1)-1:0] st_depth,
  input  logic                            st_full,
  input  logic                            st_empty
);

  localparam int LineW  = $clog2(NUM_LINES);
  localparam int TotalW = npic_pkg::TotalW;

  npic_pkg::npic_state_t  state, state_next;
  npic_pkg::npic_cmd_t    cmd_q;
  npic_pkg::npic_status_t status_q;

  logic                     cur_valid;
  logic [LineW-1:0]         cur_line;
  logic [PRIORITY_BITS-1:0] cur_pri;
  logic [TotalW-1:0]        total;
  logic [LineW-1:0]         entered_q;
  logic                     pre_q;
  logic [LineW-1:0]         scan_cnt;
  logic                     eval_on;
  logic [LineW-1:0]         eval_idx;
  logic                     found;
  logic [LineW-1:0]         best;
  logic [PRIORITY_BITS-1:0] win_pri;

  logic                     in_range;
  logic                     line_cmd;
  logic [LineW-1:0]         cmd_line;
  logic [PRIORITY_BITS-1:0] cmd_pri;
  logic                     hit;
  logic                     commit_ok;

  assign in_range = int'(cmd_q.irq_index) < NUM_LINES;
  assign line_cmd = (cmd_q.mode == npic_pkg::MODE_SET_PRI)
                 || (cmd_q.mode == npic_pkg::MODE_ENABLE)
                 || (cmd_q.mode == npic_pkg::MODE_DISABLE)
                 || (cmd_q.mode == npic_pkg::MODE_SET_PENDING);
  assign cmd_line = LineW'(cmd_q.irq_index);
  assign cmd_pri  = PRIORITY_BITS'(cmd_q.priority_value);

  // candidate must beat the running handler and the best seen so far
  assign hit = eval_on && tb_rd_flags.pending && tb_rd_flags.enable && !tb_rd_flags.active
            && (!cur_valid || (tb_rd_pri < cur_pri))
            && (!found || (tb_rd_pri < win_pri));

  // preempting with a full stack enters nothing; the line stays pending
  assign commit_ok = found && !(cur_valid && st_full);

  always_comb begin
    state_next = state;
    case (state)
      npic_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = npic_pkg::ST_DECODE;
      end
      npic_pkg::ST_DECODE: begin
        if (line_cmd) begin
          state_next = in_range ? npic_pkg::ST_LINE_WR : npic_pkg::ST_DONE;
        end else if (cmd_q.mode == npic_pkg::MODE_DISPATCH) begin
          state_next = npic_pkg::ST_SCAN;
        end else if (cmd_q.mode == npic_pkg::MODE_RETURN) begin
          state_next = cur_valid ? npic_pkg::ST_RET_WR : npic_pkg::ST_DONE;
        end else begin
          state_next = npic_pkg::ST_DONE;
        end
      end
      npic_pkg::ST_LINE_WR:   state_next = npic_pkg::ST_DONE;
      npic_pkg::ST_RET_WR: begin
        state_next = st_empty ? npic_pkg::ST_SCAN : npic_pkg::ST_POP_WAIT;
      end
      npic_pkg::ST_POP_WAIT:  state_next = npic_pkg::ST_POP_PRI;
      npic_pkg::ST_POP_PRI:   state_next = npic_pkg::ST_SCAN;
      npic_pkg::ST_SCAN: begin
        if (scan_cnt == LineW'(NUM_LINES - 1)) state_next = npic_pkg::ST_SCAN_LAST;
      end
      npic_pkg::ST_SCAN_LAST: state_next = npic_pkg::ST_COMMIT;
      npic_pkg::ST_COMMIT:    state_next = npic_pkg::ST_DONE;
      npic_pkg::ST_DONE: begin
        if (res_ready) state_next = npic_pkg::ST_IDLE;
      end
      default:                state_next = npic_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != npic_pkg::ST_IDLE);
    res_valid    = 1'b0;
    tb_rd_en     = 1'b0;
    tb_rd_addr   = cmd_line;
    tb_wr_en     = 1'b0;
    tb_wr_addr   = cmd_line;
    tb_wr_pri    = tb_rd_pri;
    tb_wr_flags  = tb_rd_flags;
    st_push      = 1'b0;
    st_push_line = cur_line;
    st_pop       = 1'b0;
    case (state)
      npic_pkg::ST_DECODE: begin
        if (line_cmd && in_range) begin
          tb_rd_en = 1'b1;
        end else if ((cmd_q.mode == npic_pkg::MODE_RETURN) && cur_valid) begin
          tb_rd_en   = 1'b1;
          tb_rd_addr = cur_line;
        end
      end
      npic_pkg::ST_LINE_WR: begin
        tb_wr_en = 1'b1;
        case (cmd_q.mode)
          npic_pkg::MODE_SET_PRI:     tb_wr_pri           = cmd_pri;
          npic_pkg::MODE_ENABLE:      tb_wr_flags.enable  = 1'b1;
          npic_pkg::MODE_DISABLE:     tb_wr_flags.enable  = 1'b0;
          npic_pkg::MODE_SET_PENDING: tb_wr_flags.pending = 1'b1;
          default:                    tb_wr_en            = 1'b0;
        endcase
      end
      npic_pkg::ST_RET_WR: begin
        // retire the running line, then pop its predecessor if any
        tb_wr_en           = 1'b1;
        tb_wr_addr         = cur_line;
        tb_wr_flags.active = 1'b0;
        st_pop             = !st_empty;
      end
      npic_pkg::ST_POP_WAIT: begin
        tb_rd_en   = 1'b1;
        tb_rd_addr = st_pop_line;
      end
      npic_pkg::ST_SCAN: begin
        tb_rd_en   = 1'b1;
        tb_rd_addr = scan_cnt;
      end
      npic_pkg::ST_COMMIT: begin
        if (commit_ok) begin
          tb_wr_en    = 1'b1;
          tb_wr_addr  = best;
          tb_wr_pri   = win_pri;
          tb_wr_flags = '{enable: 1'b1, pending: 1'b0, active: 1'b1};
          st_push     = cur_valid;
        end
      end
      npic_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npic_pkg::ST_IDLE;
      cur_valid <= 1'b0;
      total     <= '0;
      found     <= 1'b0;
      eval_on   <= 1'b0;
    end else begin
      state   <= state_next;
      eval_on <= (state == npic_pkg::ST_SCAN);
      if (state == npic_pkg::ST_DECODE) begin
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
      if ((state == npic_pkg::ST_RET_WR) && st_empty) begin
        cur_valid <= 1'b0;
      end else if ((state == npic_pkg::ST_COMMIT) && commit_ok) begin
        cur_valid <= 1'b1;
      end
      if ((state == npic_pkg::ST_DECODE) && (cmd_q.mode == npic_pkg::MODE_CLEAR_COUNT)) begin
        total <= '0;
      end else if ((state == npic_pkg::ST_COMMIT) && commit_ok && cur_valid && (total != '1)) begin
        total <= total + TotalW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == npic_pkg::ST_IDLE) && cmd_valid) begin
      cmd_q <= cmd;
    end
    if (state == npic_pkg::ST_DECODE) begin
      status_q  <= ((cmd_q.mode == npic_pkg::MODE_RETURN) && !cur_valid)
                   ? npic_pkg::STATUS_RET_IGNORED : npic_pkg::STATUS_NONE;
      entered_q <= '0;
      pre_q     <= 1'b0;
      scan_cnt  <= '0;
    end
    if ((state == npic_pkg::ST_LINE_WR) && (cmd_q.mode == npic_pkg::MODE_SET_PRI)
        && (cmd_line == cur_line)) begin
      cur_pri <= cmd_pri;
    end
    if (state == npic_pkg::ST_POP_WAIT) begin
      cur_line <= st_pop_line;
    end
    if (state == npic_pkg::ST_POP_PRI) begin
      cur_pri <= tb_rd_pri;
    end
    if (state == npic_pkg::ST_SCAN) begin
      scan_cnt <= scan_cnt + LineW'(1);
      eval_idx <= scan_cnt;
    end
    if (hit) begin
      best    <= eval_idx;
      win_pri <= tb_rd_pri;
    end
    if ((state == npic_pkg::ST_COMMIT) && commit_ok) begin
      status_q  <= npic_pkg::STATUS_ENTERED;
      entered_q <= best;
      pre_q     <= cur_valid;
      cur_line  <= best;
      cur_pri   <= win_pri;
    end
  end

  always_comb begin
    res.status           = status_q;
    res.entered_irq      = npic_pkg::IrqW'(entered_q);
    res.preempted        = pre_q;
    res.active_valid     = cur_valid;
    res.active_irq       = cur_valid ? npic_pkg::IrqW'(cur_line) : '0;
    res.nest_depth       = npic_pkg::DepthOutW'(st_depth);
    res.preemption_total = total;
  end

endmodule

// ===== src/nested_priority_interrupt_controller_top.sv =====
// Top level of the nested priority interrupt controller: sequencer, line table,
// return stack and the response register. Uses npic_pkg and the npic_* modules.
`timescale 1ns / 1ps

// Takes one command word at a time and returns one response word per command.
// Priority, enable and pending commands are a read-modify-write of one line;
// a dispatch and a handler return also search the table, reading the single
// read port of the line table one line per cycle. The command side stalls
// while a command is in flight; a finished response waits in an output
// register so the next command is taken meanwhile. The line table comes out
// of reset ready; no clearing pass is run.

module nested_priority_interrupt_controller_top #(
  parameter int NUM_LINES     = 64,
  parameter int PRIORITY_BITS = 4,
  parameter int NEST_DEPTH    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  npic_pkg::npic_cmd_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output npic_pkg::npic_rsp_t rsp
);

  localparam int LineW  = $clog2(NUM_LINES);
  localparam int DepthW = $clog2(NEST_DEPTH + 1);

  npic_pkg::npic_rsp_t      res;
  logic                     res_valid;
  logic                     res_ready;
  logic                     tb_rd_en;
  logic [LineW-1:0]         tb_rd_addr;
  logic [PRIORITY_BITS-1:0] tb_rd_pri;
  npic_pkg::npic_flags_t    tb_rd_flags;
  logic                     tb_wr_en;
  logic [LineW-1:0]         tb_wr_addr;
  logic [PRIORITY_BITS-1:0] tb_wr_pri;
  npic_pkg::npic_flags_t    tb_wr_flags;
  logic                     st_push;
  logic [LineW-1:0]         st_push_line;
  logic                     st_pop;
  logic [LineW-1:0]         st_pop_line;
  logic [DepthW-1:0]        st_depth;
  logic                     st_full;
  logic                     st_empty;

  assign res_ready = !rsp_valid || !rsp_stall;

  npic_ctrl #(
    .NUM_LINES    (NUM_LINES),
    .PRIORITY_BITS(PRIORITY_BITS),
    .NEST_DEPTH   (NEST_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .busy        (cmd_stall),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res),
    .tb_rd_en    (tb_rd_en),
    .tb_rd_addr  (tb_rd_addr),
    .tb_rd_pri   (tb_rd_pri),
    .tb_rd_flags (tb_rd_flags),
    .tb_wr_en    (tb_wr_en),
    .tb_wr_addr  (tb_wr_addr),
    .tb_wr_pri   (tb_wr_pri),
    .tb_wr_flags (tb_wr_flags),
    .st_push     (st_push),
    .st_push_line(st_push_line),
    .st_pop      (st_pop),
    .st_pop_line (st_pop_line),
    .st_depth    (st_depth),
    .st_full     (st_full),
    .st_empty    (st_empty)
  );

  npic_line_table #(
    .NUM_LINES    (NUM_LINES),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_line_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tb_rd_en),
    .rd_addr (tb_rd_addr),
    .rd_pri  (tb_rd_pri),
    .rd_flags(tb_rd_flags),
    .wr_en   (tb_wr_en),
    .wr_addr (tb_wr_addr),
    .wr_pri  (tb_wr_pri),
    .wr_flags(tb_wr_flags)
  );

  npic_ret_stack #(
    .NEST_DEPTH(NEST_DEPTH),
    .LINE_W    (LineW)
  ) u_ret_stack (
    .clk      (clk),
    .rst      (rst),
    .push     (st_push),
    .push_line(st_push_line),
    .pop      (st_pop),
    .pop_line (st_pop_line),
    .depth    (st_depth),
    .full     (st_full),
    .empty    (st_empty)
  );

  // response register: load when empty or being taken, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    st_depth <= DepthW'(NEST_DEPTH))
    else $error("return stack depth above its size");

  a_entered_active: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == npic_pkg::STATUS_ENTERED)
    |-> rsp.active_valid && (rsp.active_irq == rsp.entered_irq))
    else $error("entered line is not the running handler");

  a_preempt_entered: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.preempted |-> (rsp.status == npic_pkg::STATUS_ENTERED))
    else $error("preemption reported without an entry");

  a_ignored_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == npic_pkg::STATUS_RET_IGNORED) |-> !rsp.active_valid)
    else $error("ignored return while a handler runs");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command side not busy after accepting a word");

endmodule
